// ===== hw/rtl/hall_period_speedometer_core_macros.svh =====
// ----------------------------------------------------------------------------
// hall period speedometer assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef HALL_PERIOD_SPEEDOMETER_CORE_MACROS_SVH
`define HALL_PERIOD_SPEEDOMETER_CORE_MACROS_SVH

// clocked property, ignored while reset is asserted
`define HPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, also checked during reset
`define HPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hps_pkg.sv =====
// ----------------------------------------------------------------------------
// hps_pkg
// types and constants shared by the hall period speedometer modules
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int unsigned SPEED_W   = 25;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned PROD_W    = 56;
  localparam int unsigned FRAC_W    = 16;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
  localparam logic [3:0]         COUNT_MAX = 4'd15;

  // register reset values
  localparam logic [31:0] RATE_RST  = 32'd100000;
  localparam logic [23:0] SCALE_RST = 24'd988383;
  localparam logic [3:0]  STALL_RST = 4'd5;

  // register indexes
  typedef enum logic [1:0] {
    REG_RATE  = 2'd0,
    REG_SCALE = 2'd1,
    REG_STALL = 2'd2
  } hps_reg_e;

  // item kinds
  localparam logic REQ_EDGE   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] timestamp;
  } hps_in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               stalled;
  } hps_out_t;

  typedef struct packed {
    logic [31:0] rate_numerator;
    logic [23:0] speed_scale_q16;
    logic [3:0]  stall_threshold;
  } hps_cfg_t;

  // sequencer commands to the arithmetic unit
  typedef struct packed {
    logic load;
    logic step;
    logic mul;
  } hps_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_MUL  = 2'd2,
    ST_FIN  = 2'd3
  } hps_state_e;

endpackage

// ===== hw/rtl/hps_regs.sv =====
// ----------------------------------------------------------------------------
// hps_regs
// apb register file for numerator, wheel scale and stall threshold
// ----------------------------------------------------------------------------
module hps_regs import hps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output hps_cfg_t    cfg_o
);

  hps_cfg_t cfg_q;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_numerator  <= RATE_RST;
      cfg_q.speed_scale_q16 <= SCALE_RST;
      cfg_q.stall_threshold <= STALL_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_RATE:  cfg_q.rate_numerator  <= pwdata;
        REG_SCALE: cfg_q.speed_scale_q16 <= pwdata[23:0];
        REG_STALL: cfg_q.stall_threshold <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      REG_RATE:  prdata = cfg_q.rate_numerator;
      REG_SCALE: prdata = {8'd0, cfg_q.speed_scale_q16};
      REG_STALL: prdata = {28'd0, cfg_q.stall_threshold};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/hps_arith.sv =====
// ----------------------------------------------------------------------------
// hps_arith
// shared restoring divider, one quotient bit a cycle, then one scale multiply
// ----------------------------------------------------------------------------
module hps_arith import hps_pkg::*; (
  input  logic              clk_i,
  input  hps_ctrl_t         ctrl_i,
  input  logic [31:0]       dividend_i,
  input  logic [31:0]       divisor_i,
  input  logic [23:0]       scale_i,
  output logic [PROD_W-1:0] product_o
);

  logic [31:0]       rem_q, quo_q;
  logic [32:0]       rem_sh, diff;
  logic              ge;
  logic [PROD_W-1:0] prod_q, mul_full;

  // one trial subtract per step
  assign rem_sh   = {rem_q, quo_q[31]};
  assign diff     = rem_sh - {1'b0, divisor_i};
  assign ge       = ~diff[32];
  assign mul_full = PROD_W'(quo_q) * PROD_W'(scale_i);

  // divider state and product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= 32'd0;
      quo_q <= dividend_i;
    end else if (ctrl_i.step) begin
      rem_q <= ge ? diff[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
    if (ctrl_i.mul) begin
      prod_q <= mul_full;
    end
  end

  assign product_o = prod_q;

endmodule

// ===== hw/rtl/hall_period_speedometer_core.sv =====
// ----------------------------------------------------------------------------
// hall_period_speedometer_core
// hall sensor period tachometer with scaled, stall-aware speed output
// ----------------------------------------------------------------------------
// A Hall edge beat is taken while idle and leaves the block idle and ready. A
// sample beat passes through a load of the divider, 32 steps of the shared
// restoring divider (one quotient bit per cycle), the 32x24 scale multiply and
// a final state that saturates and updates the repeat counter, and then its
// result beat is offered; it stays there longer only while the output register
// still holds an untaken result. No clearing pass follows reset.
module hall_period_speedometer_core import hps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hps_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output hps_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hps_cfg_t          cfg;
  hps_ctrl_t         ctrl;
  hps_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] product;

  logic               awaiting_q;
  logic [31:0]        start_q, period_q;
  logic [SPEED_W-1:0] prev_q, cur;
  logic [3:0]         rep_q, rep_next;
  logic               stall;
  logic               out_valid_q;
  hps_out_t           out_q;
  logic               in_fire, fin_fire, edge_fire;

  hps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hps_arith u_arith (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .dividend_i (cfg.rate_numerator),
    .divisor_i  (period_q),
    .scale_i    (cfg.speed_scale_q16),
    .product_o  (product)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign edge_fire  = in_fire & (in_data_i.req_type == REQ_EDGE);
  assign fin_fire   = (state_q == ST_FIN) & (~out_valid_q | out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire && in_data_i.req_type == REQ_SAMPLE) state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_FIN;
      ST_FIN:  if (fin_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE: ctrl.load = in_fire;
      ST_DIV:  ctrl.step = 1'b1;
      ST_MUL:  ctrl.mul  = 1'b1;
      default: ctrl      = '0;
    endcase
  end

  // saturate scaled speed, zero with no period yet
  always_comb begin
    if (period_q == 32'd0) begin
      cur = '0;
    end else if (|product[PROD_W-1:FRAC_W+SPEED_W]) begin
      cur = SPEED_MAX;
    end else begin
      cur = product[FRAC_W+SPEED_W-1:FRAC_W];
    end
  end

  // repeat run counter and stall decision
  always_comb begin
    if (cur == prev_q) begin
      rep_next = (rep_q == COUNT_MAX) ? rep_q : rep_q + 4'd1;
    end else begin
      rep_next = 4'd0;
    end
    stall = rep_next > cfg.stall_threshold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // edge tracking and speed history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      start_q    <= 32'd0;
      period_q   <= 32'd0;
      prev_q     <= '0;
      rep_q      <= 4'd0;
    end else begin
      if (edge_fire) begin
        if (!awaiting_q) begin
          start_q    <= in_data_i.timestamp;
          awaiting_q <= 1'b1;
        end else begin
          awaiting_q <= 1'b0;
          if (in_data_i.timestamp > start_q) period_q <= in_data_i.timestamp - start_q;
        end
      end
      if (fin_fire) begin
        prev_q <= cur;
        rep_q  <= rep_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_q.speed   <= stall ? '0 : cur;
      out_q.stalled <= stall;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/hps_checker.sv =====
// ----------------------------------------------------------------------------
// hps_checker
// port-level checks for the hall period speedometer, bound to the top level
// ----------------------------------------------------------------------------
`include "hall_period_speedometer_core_macros.svh"

module hps_checker import hps_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input hps_in_t     in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input hps_out_t    out_data_o
);

  logic out_wait, sample_beat, edge_beat;

  assign out_wait    = out_valid_o && !out_ready_i;
  assign sample_beat = in_valid_i && in_ready_o && in_data_i.req_type == REQ_SAMPLE;
  assign edge_beat   = in_valid_i && in_ready_o && in_data_i.req_type == REQ_EDGE;

  // a stalled result beat holds
  `HPS_ASSERT(a_out_hold, clk_i, rst_ni,
              out_wait |=> out_valid_o && $stable(out_data_o),
              "result beat changed while stalled")

  // stall flag forces zero speed
  `HPS_ASSERT(a_stall_zero, clk_i, rst_ni,
              out_valid_o && out_data_o.stalled |-> out_data_o.speed == '0,
              "stalled result with nonzero speed")

  // a sample keeps the block busy while it divides
  `HPS_ASSERT(a_sample_busy, clk_i, rst_ni,
              sample_beat |=> !in_ready_o,
              "ready right after sample beat")

  // an edge beat leaves the block ready in the next cycle
  `HPS_ASSERT(a_edge_quick, clk_i, rst_ni,
              edge_beat |=> in_ready_o,
              "not ready after edge beat")

  // a result beat never directly follows a sampled reset
  `HPS_ASSERT_ALWAYS(a_rst_quiet, clk_i,
                     !rst_ni |=> !out_valid_o,
                     "result valid during reset")

endmodule

bind hall_period_speedometer_core hps_checker u_hps_checker (.*);
